// ===== rtl/qstm_pkg.sv =====
package qstm_pkg;

	localparam int QW = 16;
	localparam int PW = 32;
	localparam int TW = 35;
	localparam int RW = 32;
	localparam int DIVW = 25;

	localparam logic [TW-1:0] ONE_Q30 = TW'(64'sd1073741824);
	localparam logic [PW-1:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [RW-1:0] RECIP_SAT = 32'h7FFF_FFFF;
	localparam logic [1:0] VEC_POS = 2'd3;
	localparam logic [1:0] VEC_LAST_ROT = 2'd2;

	typedef struct packed {
		logic mode;
		logic signed [QW-1:0] qw;
		logic signed [QW-1:0] qx;
		logic signed [QW-1:0] qy;
		logic signed [QW-1:0] qz;
		logic signed [QW-1:0] sx;
		logic signed [QW-1:0] sy;
		logic signed [QW-1:0] sz;
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] py;
		logic signed [PW-1:0] pz;
	} xform_t;

	typedef struct packed {
		logic [1:0] vidx;
		logic signed [PW-1:0] e0;
		logic signed [PW-1:0] e1;
		logic signed [PW-1:0] e2;
		logic signed [PW-1:0] e3;
		logic last;
	} vec_t;

	// Saturate a signed value to the 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (v > hi) sat32 = 32'h7FFF_FFFF;
		else if (v < lo) sat32 = 32'h8000_0000;
		else sat32 = v[31:0];
	endfunction

endpackage

// ===== rtl/quaternion_scale_transform_matrix_core.sv =====
// An accepted item passes the front-end line, the serializer issue register, the
// multiply stage and the round and saturate stage before its first vector is presented.
// One vector per cycle unless m_tready stalls; mode 0 items give four, mode 1 three.
// The front end (products, terms, 25-stage reciprocal divider) moves in lockstep.
// Reset clears all valid bits and the serializer; payload registers are not reset.
module quaternion_scale_transform_matrix_core (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: mode, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z,
	// pos_x, pos_y, pos_z (lowest bit up), zero padded to 216 bits
	input  logic [215:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: vector_index, elem0, elem1, elem2, elem3 (lowest bit up), padded
	output logic [135:0] m_tdata,
	output logic m_tlast
);
	import qstm_pkg::*;

	localparam int FL = DIVW;

	xform_t in_x;
	assign in_x.mode = s_tdata[0];
	assign in_x.qw = s_tdata[16:1];
	assign in_x.qx = s_tdata[32:17];
	assign in_x.qy = s_tdata[48:33];
	assign in_x.qz = s_tdata[64:49];
	assign in_x.sx = s_tdata[80:65];
	assign in_x.sy = s_tdata[96:81];
	assign in_x.sz = s_tdata[112:97];
	assign in_x.px = s_tdata[144:113];
	assign in_x.py = s_tdata[176:145];
	assign in_x.pz = s_tdata[208:177];

	logic adv, busy, out_v;
	vec_t vec;
	assign adv = !m_tvalid || m_tready;

	// Front-end shift line: valid and item move with the divider stages.
	logic v_q [FL+1];
	xform_t x_q [FL+1];
	logic feed_stall;
	assign feed_stall = busy;
	assign s_tready = adv && !feed_stall;
	logic fe_en;
	assign fe_en = adv && !feed_stall;

	assign v_q[0] = s_tvalid;
	assign x_q[0] = in_x;
	for (genvar i = 0; i < FL; i++) begin : g_line
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[i+1] <= 1'b0;
			else if (fe_en) v_q[i+1] <= v_q[i];
		end
		always_ff @(posedge clk) begin
			if (fe_en) x_q[i+1] <= x_q[i];
		end
	end

	logic signed [RW-1:0] rx, ry, rz;
	qstm_recip u_rx (.clk, .arst_n, .en(fe_en), .s(in_x.sx), .recip(rx));
	qstm_recip u_ry (.clk, .arst_n, .en(fe_en), .s(in_x.sy), .recip(ry));
	qstm_recip u_rz (.clk, .arst_n, .en(fe_en), .s(in_x.sz), .recip(rz));

	// Terms are built from the item DIVW-2 stages down the line so they land
	// at the divider output.
	logic signed [TW-1:0] rot [9];
	qstm_rot u_rot (.clk, .en(fe_en), .qw(x_q[DIVW-2].qw), .qx(x_q[DIVW-2].qx),
		.qy(x_q[DIVW-2].qy), .qz(x_q[DIVW-2].qz), .rot(rot));

	xform_t cur;
	assign cur = x_q[DIVW];

	qstm_vec u_vec (.clk, .arst_n, .start(v_q[DIVW] && fe_en), .mode(cur.mode), .rot(rot),
		.sx(cur.sx), .sy(cur.sy), .sz(cur.sz), .rx(rx), .ry(ry), .rz(rz),
		.px(cur.px), .py(cur.py), .pz(cur.pz), .adv(adv), .busy(busy),
		.valid_out(out_v), .vec_out(vec));

	logic unused_tail;
	assign unused_tail = ^s_tdata[215:209];

	assign m_tvalid = out_v;
	assign m_tlast = vec.last;
	assign m_tdata = {6'b0, vec.e3, vec.e2, vec.e1, vec.e0, vec.vidx};
endmodule

// ===== rtl/qstm_recip.sv =====
// Pipelined restoring divider: one quotient bit per stage, giving the
// rounded Q16.16 reciprocal 2^24 / |S| of a Q8.8 scale with its sign.
module qstm_recip (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic signed [qstm_pkg::QW-1:0] s,
	output logic signed [qstm_pkg::RW-1:0] recip
);
	import qstm_pkg::*;

	localparam int NS = DIVW;

	logic [DIVW-1:0] num_q [NS+1];
	logic [DIVW-1:0] rem_q [NS+1];
	logic [DIVW-1:0] quo_q [NS+1];
	logic [QW-1:0] mag_q [NS+1];
	logic neg_q [NS+1];
	logic zero_q [NS+1];
	logic [QW-1:0] mag_in;

	assign mag_in = s[QW-1] ? QW'(-s) : QW'(s);

	// Stage zero holds the dividend 2^24 + |S|/2 and the divisor.
	always_comb begin
		num_q[0] = DIVW'(25'd16777216) + DIVW'(mag_in >> 1);
		rem_q[0] = '0;
		quo_q[0] = '0;
		mag_q[0] = mag_in;
		neg_q[0] = s[QW-1];
		zero_q[0] = (s == '0);
	end

	// Each stage shifts one dividend bit in and subtracts when it fits.
	for (genvar i = 0; i < NS; i++) begin : g_div
		logic [DIVW:0] trial;
		logic [DIVW-1:0] shifted;
		assign shifted = {rem_q[i][DIVW-2:0], num_q[i][DIVW-1-i]};
		assign trial = {1'b0, shifted} - {{(DIVW+1-QW){1'b0}}, mag_q[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				num_q[i+1] <= num_q[i];
				mag_q[i+1] <= mag_q[i];
				neg_q[i+1] <= neg_q[i];
				zero_q[i+1] <= zero_q[i];
				if (!trial[DIVW]) begin
					rem_q[i+1] <= trial[DIVW-1:0];
					quo_q[i+1] <= {quo_q[i][DIVW-2:0], 1'b1};
				end else begin
					rem_q[i+1] <= shifted;
					quo_q[i+1] <= {quo_q[i][DIVW-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		if (zero_q[NS]) recip = RECIP_SAT;
		else if (neg_q[NS]) recip = -RW'(quo_q[NS]);
		else recip = RW'(quo_q[NS]);
	end

	logic unused_rst;
	assign unused_rst = arst_n;
endmodule

// ===== rtl/qstm_rot.sv =====
// Two-stage rotation term builder: products, then the nine Q5.30 terms.
module qstm_rot (
	input  logic clk,
	input  logic en,
	input  logic signed [qstm_pkg::QW-1:0] qw,
	input  logic signed [qstm_pkg::QW-1:0] qx,
	input  logic signed [qstm_pkg::QW-1:0] qy,
	input  logic signed [qstm_pkg::QW-1:0] qz,
	output logic signed [qstm_pkg::TW-1:0] rot [9]
);
	import qstm_pkg::*;

	logic signed [31:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;

	// Pairwise quaternion products.
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= qx * qx; yy_s1 <= qy * qy; zz_s1 <= qz * qz;
			xy_s1 <= qx * qy; xz_s1 <= qx * qz; yz_s1 <= qy * qz;
			wx_s1 <= qw * qx; wy_s1 <= qw * qy; wz_s1 <= qw * qz;
		end
	end

	function automatic logic signed [TW-1:0] dbl(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic sub);
		logic signed [TW-1:0] t;
		t = sub ? TW'(a) - TW'(b) : TW'(a) + TW'(b);
		dbl = t <<< 1;
	endfunction

	// Rotation terms in Q5.30.
	always_ff @(posedge clk) begin
		if (en) begin
			rot[0] <= ONE_Q30 - dbl(yy_s1, zz_s1, 1'b0);
			rot[1] <= dbl(xy_s1, wz_s1, 1'b1);
			rot[2] <= dbl(xz_s1, wy_s1, 1'b0);
			rot[3] <= dbl(xy_s1, wz_s1, 1'b0);
			rot[4] <= ONE_Q30 - dbl(xx_s1, zz_s1, 1'b0);
			rot[5] <= dbl(yz_s1, wx_s1, 1'b1);
			rot[6] <= dbl(xz_s1, wy_s1, 1'b1);
			rot[7] <= dbl(yz_s1, wx_s1, 1'b0);
			rot[8] <= ONE_Q30 - dbl(xx_s1, yy_s1, 1'b0);
		end
	end
endmodule

// ===== rtl/qstm_vec.sv =====
// Vector serializer: one vector per cycle through a multiply stage and a
// round and saturate stage, with a skid-free stall on the output.
module qstm_vec (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic mode,
	input  logic signed [qstm_pkg::TW-1:0] rot [9],
	input  logic signed [qstm_pkg::QW-1:0] sx,
	input  logic signed [qstm_pkg::QW-1:0] sy,
	input  logic signed [qstm_pkg::QW-1:0] sz,
	input  logic signed [qstm_pkg::RW-1:0] rx,
	input  logic signed [qstm_pkg::RW-1:0] ry,
	input  logic signed [qstm_pkg::RW-1:0] rz,
	input  logic signed [qstm_pkg::PW-1:0] px,
	input  logic signed [qstm_pkg::PW-1:0] py,
	input  logic signed [qstm_pkg::PW-1:0] pz,
	input  logic adv,
	output logic busy,
	output logic valid_out,
	output qstm_pkg::vec_t vec_out
);
	import qstm_pkg::*;

	// Held item while its vectors are issued.
	logic signed [TW-1:0] rot_q [9];
	logic signed [RW-1:0] f_q [3];
	logic signed [PW-1:0] p_q [3];
	logic mode_q;
	logic act_q;
	logic [1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= '0;
		end else if (adv) begin
			if (start) begin
				act_q <= 1'b1;
				idx_q <= '0;
			end else if (act_q) begin
				if ((mode_q && idx_q == VEC_LAST_ROT) || idx_q == VEC_POS) act_q <= 1'b0;
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && start) begin
			rot_q <= rot;
			mode_q <= mode;
			f_q[0] <= mode ? rx : RW'(sx);
			f_q[1] <= mode ? ry : RW'(sy);
			f_q[2] <= mode ? rz : RW'(sz);
			p_q[0] <= px; p_q[1] <= py; p_q[2] <= pz;
		end
	end

	assign busy = act_q && !((mode_q && idx_q == VEC_LAST_ROT) || idx_q == VEC_POS);

	// Multiply stage.
	logic signed [RW+TW-1:0] prod_s1 [3];
	logic signed [PW-1:0] pos_s1 [3];
	logic v_s1, mode_s1, last_s1;
	logic [1:0] idx_s1;
	logic signed [RW-1:0] fsel;

	always_comb begin
		case (idx_q)
			2'd0: fsel = f_q[0];
			2'd1: fsel = f_q[1];
			default: fsel = f_q[2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= act_q;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int e = 0; e < 3; e++) begin
				case (idx_q)
					2'd0: prod_s1[e] <= fsel * rot_q[e];
					2'd1: prod_s1[e] <= fsel * rot_q[3+e];
					default: prod_s1[e] <= fsel * rot_q[6+e];
				endcase
				pos_s1[e] <= p_q[e];
			end
			mode_s1 <= mode_q;
			idx_s1 <= idx_q;
			last_s1 <= (mode_q && idx_q == VEC_LAST_ROT) || idx_q == VEC_POS;
		end
	end

	// Round and saturate stage.
	function automatic logic signed [PW-1:0] rnd(input logic signed [RW+TW-1:0] p,
			input logic nm);
		logic signed [RW+TW-1:0] t;
		t = nm ? p + (RW+TW)'(64'sd536870912) : p + (RW+TW)'(64'sd2097152);
		t = nm ? t >>> 30 : t >>> 22;
		rnd = sat32(64'(t));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_out <= 1'b0;
		else if (adv) valid_out <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_out.vidx <= idx_s1;
			vec_out.last <= last_s1;
			if (idx_s1 == VEC_POS) begin
				vec_out.e0 <= pos_s1[0];
				vec_out.e1 <= pos_s1[1];
				vec_out.e2 <= pos_s1[2];
				vec_out.e3 <= ONE_Q16;
			end else begin
				vec_out.e0 <= rnd(prod_s1[0], mode_s1);
				vec_out.e1 <= rnd(prod_s1[1], mode_s1);
				vec_out.e2 <= rnd(prod_s1[2], mode_s1);
				vec_out.e3 <= '0;
			end
		end
	end
endmodule
